/* hdl/mer_pkg.sv */
package mer_pkg;

  localparam int AXIS_BITS_DEF = 10;
  localparam int OFS_W = 10;
  localparam int SCR_W = 12;
  localparam int CTR_W = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CTR_W-1:0] CENTER_RESET = CTR_W'(300);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SQ_A,
    MUL_SQ_B,
    MUL_ASQ_B,
    MUL_LHS,
    MUL_RHS,
    MUL_GAIN1,
    MUL_VERT1,
    MUL_HH,
    MUL_BSQ_P,
    MUL_VV,
    MUL_ASQ_P,
    MUL_ASQ_BSQ,
    MUL_VERT2,
    MUL_GAIN2
  } mul_sel_t;

  typedef enum logic [2:0] {
    DEC_HOLD,
    DEC_INIT,
    DEC_LOAD,
    DEC_ADD,
    DEC_SUB
  } dec_op_t;

  typedef struct packed {
    logic     load_axes;
    logic     ld_asq;
    logic     ld_bsq;
    logic     ld_tmp;
    logic     init;
    logic     set_r2;
    logic     latch_neg;
    logic     x_inc;
    logic     y_dec;
    logic     emit;
    mul_sel_t mul_sel;
    dec_op_t  dec_op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic region2;
    logic neg;
    logic r1_go;
  } dp_sts_t;

  typedef struct packed {
    logic [OFS_W-1:0]        offset_x;
    logic [OFS_W-1:0]        offset_y;
    logic signed [SCR_W-1:0] screen_x_plus;
    logic signed [SCR_W-1:0] screen_x_minus;
    logic signed [SCR_W-1:0] screen_y_plus;
    logic signed [SCR_W-1:0] screen_y_minus;
    logic                    finished;
  } point_t;

endpackage

/* hdl/mer_if.sv */
interface mer_cmd_if #(
  parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [AXIS_BITS-1:0] semi_x;
  logic [AXIS_BITS-1:0] semi_y;

  modport source (output valid, output command, output semi_x, output semi_y, input ready);
  modport sink (input valid, input command, input semi_x, input semi_y, output ready);
endinterface

interface mer_pt_if;
  import mer_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OFS_W-1:0]        offset_x;
  logic [OFS_W-1:0]        offset_y;
  logic signed [SCR_W-1:0] screen_x_plus;
  logic signed [SCR_W-1:0] screen_x_minus;
  logic signed [SCR_W-1:0] screen_y_plus;
  logic signed [SCR_W-1:0] screen_y_minus;
  logic                    finished;

  modport source (
    output valid, output offset_x, output offset_y, output screen_x_plus,
    output screen_x_minus, output screen_y_plus, output screen_y_minus,
    output finished, input ready
  );
  modport sink (
    input valid, input offset_x, input offset_y, input screen_x_plus,
    input screen_x_minus, input screen_y_plus, input screen_y_minus,
    input finished, output ready
  );
endinterface

/* hdl/mer_datapath.sv */
module mer_datapath #(
  parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mer_pkg::dp_cmd_t               cmd,
  output mer_pkg::dp_sts_t               sts,
  input  logic [AXIS_BITS-1:0]           semi_x,
  input  logic [AXIS_BITS-1:0]           semi_y,
  input  logic                           cfg_wr_en,
  input  logic [mer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mer_pkg::CTR_W-1:0]      cfg_wdata,
  output mer_pkg::point_t                point
);
  import mer_pkg::*;

  localparam int MUL_W = 2 * AXIS_BITS + 3;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DEC_W = 4 * AXIS_BITS + 8;
  localparam int SQ_W = 2 * AXIS_BITS;
  localparam int CMP_W = 3 * AXIS_BITS + 1;

  logic [AXIS_BITS-1:0]     a_r;
  logic [AXIS_BITS-1:0]     b_r;
  logic [SQ_W-1:0]          asq_r;
  logic [SQ_W-1:0]          bsq_r;
  logic [CMP_W-1:0]         tmp_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DEC_W-1:0]  dec_r;
  logic signed [DEC_W-1:0]  dec_nxt;
  logic                     neg_r;
  logic [AXIS_BITS-1:0]     pos_x_r;
  logic [AXIS_BITS-1:0]     pos_y_r;
  logic                     r2_r;
  logic                     done_r;
  logic [CTR_W-1:0]         ctr_x_r;
  logic [CTR_W-1:0]         ctr_y_r;
  point_t                   point_r;

  logic signed [MUL_W-1:0]  xs;
  logic signed [MUL_W-1:0]  ys;
  logic signed [MUL_W-1:0]  as_v;
  logic signed [MUL_W-1:0]  bs_v;
  logic signed [MUL_W-1:0]  asq_s;
  logic signed [MUL_W-1:0]  bsq_s;
  logic signed [MUL_W-1:0]  pp_s;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [DEC_W-1:0]  p_ext;
  logic signed [DEC_W-1:0]  p4;
  logic [OFS_W-1:0]         ofs_x;
  logic [OFS_W-1:0]         ofs_y;

  assign xs = MUL_W'(pos_x_r);
  assign ys = MUL_W'(pos_y_r);
  assign as_v = MUL_W'(a_r);
  assign bs_v = MUL_W'(b_r);
  assign asq_s = MUL_W'(asq_r);
  assign bsq_s = MUL_W'(bsq_r);
  assign pp_s = prod_r[MUL_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_SQ_A: begin
        mul_a = as_v;
        mul_b = as_v;
      end
      MUL_SQ_B: begin
        mul_a = bs_v;
        mul_b = bs_v;
      end
      MUL_ASQ_B: begin
        mul_a = asq_s;
        mul_b = bs_v;
      end
      MUL_LHS: begin
        mul_a = asq_s;
        mul_b = (ys <<< 1) - MUL_W'(1);
      end
      MUL_RHS: begin
        mul_a = bsq_s;
        mul_b = xs + MUL_W'(1);
      end
      MUL_GAIN1: begin
        mul_a = bsq_s;
        mul_b = (xs <<< 1) + MUL_W'(3);
      end
      MUL_VERT1: begin
        mul_a = asq_s;
        mul_b = (ys <<< 1) - MUL_W'(2);
      end
      MUL_HH: begin
        mul_a = (xs <<< 1) + MUL_W'(1);
        mul_b = (xs <<< 1) + MUL_W'(1);
      end
      MUL_BSQ_P: begin
        mul_a = bsq_s;
        mul_b = pp_s;
      end
      MUL_VV: begin
        mul_a = ys - MUL_W'(1);
        mul_b = ys - MUL_W'(1);
      end
      MUL_ASQ_P: begin
        mul_a = asq_s;
        mul_b = pp_s;
      end
      MUL_ASQ_BSQ: begin
        mul_a = asq_s;
        mul_b = bsq_s;
      end
      MUL_VERT2: begin
        mul_a = asq_s;
        mul_b = MUL_W'(3) - (ys <<< 1);
      end
      MUL_GAIN2: begin
        mul_a = bsq_s;
        mul_b = (xs <<< 1) + MUL_W'(2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_ext = DEC_W'(prod_r);
  assign p4 = p_ext <<< 2;

  always_comb begin
    case (cmd.dec_op)
      DEC_INIT: dec_nxt = (DEC_W'(bsq_r) <<< 2) + DEC_W'(asq_r) - p4;
      DEC_LOAD: dec_nxt = p_ext;
      DEC_ADD:  dec_nxt = dec_r + p4;
      DEC_SUB:  dec_nxt = dec_r - p4;
      default:  dec_nxt = dec_r;
    endcase
  end

  assign ofs_x = OFS_W'(pos_x_r);
  assign ofs_y = OFS_W'(pos_y_r);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    dec_r <= dec_nxt;
    if (cmd.load_axes) begin
      a_r <= semi_x;
      b_r <= semi_y;
    end
    if (cmd.ld_asq) begin
      asq_r <= prod_r[SQ_W-1:0];
    end
    if (cmd.ld_bsq) begin
      bsq_r <= prod_r[SQ_W-1:0];
    end
    if (cmd.ld_tmp) begin
      tmp_r <= prod_r[CMP_W-1:0];
    end
    if (cmd.latch_neg) begin
      neg_r <= dec_r[DEC_W-1];
    end
    if (cmd.emit) begin
      point_r.offset_x <= ofs_x;
      point_r.offset_y <= ofs_y;
      point_r.screen_x_plus <= SCR_W'(ctr_x_r) + SCR_W'(ofs_x);
      point_r.screen_x_minus <= SCR_W'(ctr_x_r) - SCR_W'(ofs_x);
      point_r.screen_y_plus <= SCR_W'(ctr_y_r) + SCR_W'(ofs_y);
      point_r.screen_y_minus <= SCR_W'(ctr_y_r) - SCR_W'(ofs_y);
      point_r.finished <= done_r | (pos_y_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      r2_r <= 1'b0;
      done_r <= 1'b1;
      ctr_x_r <= CENTER_RESET;
      ctr_y_r <= CENTER_RESET;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CENTER_X: ctr_x_r <= cfg_wdata;
          CFG_CENTER_Y: ctr_y_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.init) begin
        pos_x_r <= '0;
        pos_y_r <= b_r;
        r2_r <= 1'b0;
        done_r <= 1'b0;
      end else begin
        if (cmd.x_inc) begin
          pos_x_r <= pos_x_r + AXIS_BITS'(1);
        end
        if (cmd.y_dec) begin
          pos_y_r <= pos_y_r - AXIS_BITS'(1);
        end
        if (cmd.set_r2) begin
          r2_r <= 1'b1;
        end
        if (cmd.emit) begin
          done_r <= done_r | (pos_y_r == '0);
        end
      end
    end
  end

  assign sts.done = done_r;
  assign sts.region2 = r2_r;
  assign sts.neg = neg_r;
  assign sts.r1_go = {1'b0, tmp_r} > {prod_r[CMP_W-1:0], 1'b0};
  assign point = point_r;

`ifndef SYNTH
  a_no_y_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_dec |-> pos_y_r != '0)
    else $error("row counter stepped below zero");
`endif

endmodule

/* hdl/mer_ctrl.sv */
module mer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mer_pkg::dp_sts_t sts,
  output mer_pkg::dp_cmd_t cmd
);
  import mer_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_ASQ_B,
    ST_INIT,
    ST_LHS,
    ST_RHS,
    ST_CMP,
    ST_GAIN1,
    ST_VERT1,
    ST_UPD1,
    ST_HH,
    ST_BHH,
    ST_VV,
    ST_AVV,
    ST_ABB,
    ST_SWITCH,
    ST_VERT2,
    ST_ADD2,
    ST_UPD2,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_START) begin
            cmd.load_axes = 1'b1;
            state_nxt = ST_SQ_A;
          end else if (sts.done) begin
            state_nxt = ST_EMIT;
          end else if (sts.region2) begin
            state_nxt = ST_VERT2;
          end else begin
            state_nxt = ST_LHS;
          end
        end
      end
      ST_SQ_A: begin
        cmd.mul_sel = MUL_SQ_A;
        state_nxt = ST_SQ_B;
      end
      ST_SQ_B: begin
        cmd.ld_asq = 1'b1;
        cmd.mul_sel = MUL_SQ_B;
        state_nxt = ST_ASQ_B;
      end
      ST_ASQ_B: begin
        cmd.ld_bsq = 1'b1;
        cmd.mul_sel = MUL_ASQ_B;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        cmd.dec_op = DEC_INIT;
        state_nxt = ST_EMIT;
      end
      ST_LHS: begin
        cmd.mul_sel = MUL_LHS;
        state_nxt = ST_RHS;
      end
      ST_RHS: begin
        cmd.ld_tmp = 1'b1;
        cmd.mul_sel = MUL_RHS;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = sts.r1_go ? ST_GAIN1 : ST_HH;
      end
      ST_GAIN1: begin
        cmd.latch_neg = 1'b1;
        cmd.mul_sel = MUL_GAIN1;
        state_nxt = ST_VERT1;
      end
      ST_VERT1: begin
        cmd.dec_op = DEC_ADD;
        cmd.mul_sel = MUL_VERT1;
        state_nxt = ST_UPD1;
      end
      ST_UPD1: begin
        cmd.dec_op = sts.neg ? DEC_HOLD : DEC_SUB;
        cmd.y_dec = !sts.neg;
        cmd.x_inc = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_HH: begin
        cmd.mul_sel = MUL_HH;
        state_nxt = ST_BHH;
      end
      ST_BHH: begin
        cmd.mul_sel = MUL_BSQ_P;
        state_nxt = ST_VV;
      end
      ST_VV: begin
        cmd.dec_op = DEC_LOAD;
        cmd.mul_sel = MUL_VV;
        state_nxt = ST_AVV;
      end
      ST_AVV: begin
        cmd.mul_sel = MUL_ASQ_P;
        state_nxt = ST_ABB;
      end
      ST_ABB: begin
        cmd.dec_op = DEC_ADD;
        cmd.mul_sel = MUL_ASQ_BSQ;
        state_nxt = ST_SWITCH;
      end
      ST_SWITCH: begin
        cmd.dec_op = DEC_SUB;
        cmd.set_r2 = 1'b1;
        state_nxt = ST_VERT2;
      end
      ST_VERT2: begin
        cmd.latch_neg = 1'b1;
        cmd.mul_sel = MUL_VERT2;
        state_nxt = ST_ADD2;
      end
      ST_ADD2: begin
        cmd.dec_op = DEC_ADD;
        cmd.y_dec = 1'b1;
        cmd.mul_sel = MUL_GAIN2;
        state_nxt = sts.neg ? ST_UPD2 : ST_EMIT;
      end
      ST_UPD2: begin
        cmd.dec_op = DEC_ADD;
        cmd.x_inc = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken again before the current transaction finished");
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still held");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

/* hdl/midpoint_ellipse_rasterizer_top.sv */
// Midpoint ellipse rasterizer. Each transaction on in_cmd is either a start
// (command 0, semi-axes on semi_x and semi_y) or a step (command 1). Every
// accepted transaction yields exactly one transaction on out_pt: the current
// first-quadrant point, its four mirrored screen coordinates about the
// center, and finished once the row offset has reached zero.
// The center is written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must do so while the block is idle, which the block does not enforce.
// Index 0 is the column, index 1 the row, both reset to 300. One shared
// multiplier with a registered product does all the multiplications, and the
// controller sequences it, so the cycle count depends on the path: a start, a
// region-one step, a region-two step, the step that crosses into region two
// and a step after completion each take their own path. A new transaction can
// be accepted in the cycle after the result is loaded.
// The result register holds its point while out_pt.ready is low; the block
// keeps working on the next transaction and waits only to load its result.
// Synchronous reset leaves the block idle, with no ellipse started: a step
// then returns the origin with finished set.
module midpoint_ellipse_rasterizer_top #(
  parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mer_cmd_if.sink                       in_cmd,
  mer_pt_if.source                      out_pt,
  input  logic                          cfg_wr_en,
  input  logic [mer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mer_pkg::CTR_W-1:0]     cfg_wdata
);
  import mer_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  point_t  point;
  logic    in_ready;
  logic    out_valid;

  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_cmd.valid),
    .in_command (in_cmd.command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_pt.ready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  mer_datapath #(
    .AXIS_BITS (AXIS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .semi_x    (in_cmd.semi_x),
    .semi_y    (in_cmd.semi_y),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .point     (point)
  );

  assign in_cmd.ready = in_ready;
  assign out_pt.valid = out_valid;
  assign out_pt.offset_x = point.offset_x;
  assign out_pt.offset_y = point.offset_y;
  assign out_pt.screen_x_plus = point.screen_x_plus;
  assign out_pt.screen_x_minus = point.screen_x_minus;
  assign out_pt.screen_y_plus = point.screen_y_plus;
  assign out_pt.screen_y_minus = point.screen_y_minus;
  assign out_pt.finished = point.finished;

endmodule

/* sim/midpoint_ellipse_rasterizer_checker.sv */
module midpoint_ellipse_rasterizer_checker
  import mer_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mer_cmd_if                   cmd_mon,
  mer_pt_if                    pt_mon,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CTR_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   outstanding,
  output int                   points_checked,
  output int                   ellipses_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CTR_W-1:0] center_x;
  logic [CTR_W-1:0] center_y;
  logic [OFS_W-1:0] pos_x;
  logic [OFS_W-1:0] pos_y;
  bit   [63:0]      dec_val;
  bit   [63:0]      a_sq;
  bit   [63:0]      b_sq;
  bit               region_two;
  bit               all_done;

  point_t pending_points[$];

  // Decision values are kept at four times the textbook value so that every
  // update is exact 64-bit integer arithmetic.
  function automatic point_t next_point(input logic cmd, input logic [OFS_W-1:0] semi_a,
                                        input logic [OFS_W-1:0] semi_b);
    bit [63:0] lhs;
    bit [63:0] rhs;
    bit [63:0] gain;
    bit [63:0] vert;
    bit [63:0] h;
    bit [63:0] v;
    bit        moved;
    point_t    pt;
    moved = 1'b0;
    if (cmd == CMD_START) begin
      a_sq = 64'(semi_a) * 64'(semi_a);
      b_sq = 64'(semi_b) * 64'(semi_b);
      pos_x = '0;
      pos_y = semi_b;
      dec_val = 4 * b_sq - 4 * a_sq * 64'(semi_b) + a_sq;
      region_two = 1'b0;
      all_done = (semi_b == 0);
    end else if (!all_done) begin
      if (!region_two) begin
        lhs = a_sq * (2 * 64'(pos_y) - 1);
        rhs = 2 * b_sq * (64'(pos_x) + 1);
        if (lhs > rhs) begin
          gain = 4 * b_sq * (2 * 64'(pos_x) + 3);
          if (dec_val[63]) begin
            dec_val += gain;
          end else begin
            dec_val += gain - 4 * a_sq * (2 * 64'(pos_y) - 2);
            pos_y = pos_y - 1'b1;
          end
          pos_x = pos_x + 1'b1;
          moved = 1'b1;
        end else begin
          h = 2 * 64'(pos_x) + 1;
          v = 64'(pos_y) - 1;
          dec_val = b_sq * h * h + 4 * a_sq * v * v - 4 * a_sq * b_sq;
          region_two = 1'b1;
        end
      end
      if (!moved) begin
        vert = 12 * a_sq - 8 * a_sq * 64'(pos_y);
        if (dec_val[63]) begin
          dec_val += 4 * b_sq * (2 * 64'(pos_x) + 2) + vert;
          pos_x = pos_x + 1'b1;
        end else begin
          dec_val += vert;
        end
        pos_y = pos_y - 1'b1;
      end
      if (pos_y == 0) begin
        all_done = 1'b1;
        ellipses_closed++;
      end
    end
    pt.offset_x = pos_x;
    pt.offset_y = pos_y;
    pt.screen_x_plus = SCR_W'(center_x) + SCR_W'(pos_x);
    pt.screen_x_minus = SCR_W'(center_x) - SCR_W'(pos_x);
    pt.screen_y_plus = SCR_W'(center_y) + SCR_W'(pos_y);
    pt.screen_y_minus = SCR_W'(center_y) - SCR_W'(pos_y);
    pt.finished = all_done;
    return pt;
  endfunction

  task automatic compare_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      center_x = CENTER_RESET;
      center_y = CENTER_RESET;
      pos_x = '0;
      pos_y = '0;
      dec_val = '0;
      a_sq = '0;
      b_sq = '0;
      region_two = 1'b0;
      all_done = 1'b1;
      pending_points.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CENTER_X: center_x = cfg_wdata;
          CFG_CENTER_Y: center_y = cfg_wdata;
          default: ;
        endcase
      end
      if (pt_mon.valid && pt_mon.ready) begin
        if (pending_points.size() == 0) begin
          $error("point transaction arrived with no point predicted");
          mismatch_count++;
        end else begin
          want = pending_points.pop_front();
          compare_field("offset_x", 32'(want.offset_x), 32'(pt_mon.offset_x));
          compare_field("offset_y", 32'(want.offset_y), 32'(pt_mon.offset_y));
          compare_field("screen_x_plus", 32'(want.screen_x_plus),
                        32'(pt_mon.screen_x_plus));
          compare_field("screen_x_minus", 32'(want.screen_x_minus),
                        32'(pt_mon.screen_x_minus));
          compare_field("screen_y_plus", 32'(want.screen_y_plus),
                        32'(pt_mon.screen_y_plus));
          compare_field("screen_y_minus", 32'(want.screen_y_minus),
                        32'(pt_mon.screen_y_minus));
          compare_field("finished", 32'(want.finished), 32'(pt_mon.finished));
          points_checked++;
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        pending_points.push_back(next_point(cmd_mon.command, cmd_mon.semi_x, cmd_mon.semi_y));
      end
    end
    outstanding <= pending_points.size();
  end

endmodule

/* sim/midpoint_ellipse_rasterizer_top_test.sv */
module midpoint_ellipse_rasterizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  localparam int IDLE_MAX = 10;
  localparam int HOLD_CYCLES = 160;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 290;
  localparam int NUM_PHASES = 6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CTR_W-1:0]     cfg_wdata;

  int mismatch_count;
  int outstanding;
  int points_checked;
  int ellipses_closed;
  int sent;
  int starts;
  int quiet_cycles;

  mer_cmd_if cmd_ch ();
  mer_pt_if  pt_ch ();

  midpoint_ellipse_rasterizer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_ch),
    .out_pt    (pt_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  midpoint_ellipse_rasterizer_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_mon         (cmd_ch),
    .pt_mon          (pt_ch),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .points_checked  (points_checked),
    .ellipses_closed (ellipses_closed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_cmd(input logic cmd, input logic [AXIS_BITS_DEF-1:0] semi_a,
                          input logic [AXIS_BITS_DEF-1:0] semi_b);
    int gap;
    gap = ((sent % 150) < 40) ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.semi_x <= semi_a;
    cmd_ch.semi_y <= semi_b;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    sent++;
    if (cmd == CMD_START) starts++;
  endtask

  task automatic trace(input logic [AXIS_BITS_DEF-1:0] semi_a,
                       input logic [AXIS_BITS_DEF-1:0] semi_b, input int steps);
    send_cmd(CMD_START, semi_a, semi_b);
    repeat (steps) send_cmd(CMD_STEP, AXIS_BITS_DEF'($urandom_range(0, 1023)),
                            AXIS_BITS_DEF'($urandom_range(0, 1023)));
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic place_center(input logic [CTR_W-1:0] cx, input logic [CTR_W-1:0] cy);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_CENTER_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= CFG_CENTER_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly complete traces of small ellipses, some partial traces of large,
  // flat or tall ones that a new start cuts short, and some random noise.
  task automatic random_burst();
    int pick;
    int n;
    logic [AXIS_BITS_DEF-1:0] a;
    logic [AXIS_BITS_DEF-1:0] b;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      a = AXIS_BITS_DEF'($urandom_range(0, 24));
      b = AXIS_BITS_DEF'($urandom_range(0, 24));
      trace(a, b, a + b + $urandom_range(1, 3));
    end else if (pick == 6) begin
      trace(AXIS_BITS_DEF'($urandom_range(0, 1023)), AXIS_BITS_DEF'($urandom_range(0, 1023)),
            $urandom_range(3, 30));
    end else if (pick == 7) begin
      trace(AXIS_BITS_DEF'($urandom_range(200, 1023)), AXIS_BITS_DEF'($urandom_range(1, 3)),
            $urandom_range(10, 40));
    end else if (pick == 8) begin
      trace(AXIS_BITS_DEF'($urandom_range(0, 3)), AXIS_BITS_DEF'($urandom_range(200, 1023)),
            $urandom_range(10, 40));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_cmd($urandom_range(0, 1) ? CMD_STEP : CMD_START,
                 AXIS_BITS_DEF'($urandom_range(0, 1023)),
                 AXIS_BITS_DEF'($urandom_range(0, 1023)));
      end
    end
  endtask

  initial begin
    logic [CTR_W-1:0] cx;
    logic [CTR_W-1:0] cy;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CENTER_X;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_STEP;
    cmd_ch.semi_x = '0;
    cmd_ch.semi_y = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(CMD_STEP, 10'd1023, 10'd1023);
    trace(10'd0, 10'd0, 1);
    trace(10'd0, 10'd4, 5);
    trace(10'd1023, 10'd1023, 2);
    trace(10'd1023, 10'd1, 3);
    trace(10'd1, 10'd1023, 3);
    trace(10'd3, 10'd2, 5);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin cx = 10'd0; cy = 10'd0; end
        1: begin cx = 10'd1023; cy = 10'd1023; end
        2: begin cx = 10'd1023; cy = 10'd0; end
        3: begin cx = 10'd0; cy = 10'd1023; end
        default: begin
          cx = CTR_W'($urandom_range(0, 1023));
          cy = CTR_W'($urandom_range(0, 1023));
        end
      endcase
      place_center(cx, cy);
      while (sent < 26 + (phase + 1) * PHASE_ITEMS) random_burst();
    end

    settle();
    $display("Checked %0d points from %0d commands, %0d starts, %0d traces run to the end.",
             points_checked, sent, starts, ellipses_closed);
    $display("Centers covered the reset value, all four corners and random positions.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The receiver holds off twice for a long stretch so that the block backs up.
  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    pt_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken == 450 || taken == 1300) begin
        pt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = ((taken % 160) < 40) ? 0 : $urandom_range(0, IDLE_MAX);
      if (wait_cycles > 0) begin
        pt_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pt_ch.ready <= 1'b1;
      do @(posedge clk); while (!(pt_ch.valid && pt_ch.ready));
      taken++;
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (pt_ch.valid && pt_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* midpoint_ellipse_rasterizer_top.f */
hdl/mer_pkg.sv
hdl/mer_if.sv
hdl/mer_datapath.sv
hdl/mer_ctrl.sv
hdl/midpoint_ellipse_rasterizer_top.sv
sim/midpoint_ellipse_rasterizer_checker.sv
sim/midpoint_ellipse_rasterizer_top_test.sv
